[design/sbd_pkg.sv]
package sbd_pkg;

   localparam int REQ_DW   = 120;
   localparam int RSP_DW   = 80;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 17;

   localparam int CW       = 34;
   localparam int DIV_NW   = 40;
   localparam int DIV_DW   = 17;
   localparam int SQ_RW    = 62;
   localparam int ROOT_W   = 31;

   typedef logic signed [CW-1:0] cword_type;

   typedef struct packed {
      logic      start;
      logic      vector;
      cword_type x;
      cword_type y;
      cword_type z;
   } cor_req_type;

   typedef struct packed {
      logic      done;
      logic      busy;
      cword_type x;
      cword_type y;
      cword_type z;
   } cor_rsp_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SLOW_SPEED     = 3'd0,
      CSR_FAST_SPEED     = 3'd1,
      CSR_SLOW_INTERVAL  = 3'd2,
      CSR_FAST_INTERVAL  = 3'd3,
      CSR_MIN_DISTANCE   = 3'd4,
      CSR_MIN_GAP        = 3'd5,
      CSR_TURN_THRESHOLD = 3'd6,
      CSR_TURN_SLOPE     = 3'd7
   } csr_idx_type;

   localparam logic signed [31:0] UDEG_TO_RAD = 32'sd314410567;
   localparam logic signed [31:0] EARTH_2R    = 32'sd12742000;
   localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
   localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
   localparam cword_type          CORDIC_K    = 34'sd652032874;
   localparam logic [32:0]        ONE_Q32     = 33'h100000000;

   function automatic cword_type atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return {2'b00, v};
   endfunction

   // seconds to milliseconds: x*1024 - x*16 - x*8
   function automatic logic [21:0] sec_to_ms(input logic [11:0] s);
      return {s, 10'b0} - {6'b0, s, 4'b0} - {7'b0, s, 3'b0};
   endfunction

   // x*64 + x*32 + x*4
   function automatic logic [16:0] times_100(input logic [9:0] s);
      return {1'b0, s, 6'b0} + {2'b0, s, 5'b0} + {5'b0, s, 2'b0};
   endfunction

endpackage

[design/sbd_cordic.sv]
module sbd_cordic
   import sbd_pkg::*;
#(
   parameter int STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  cor_req_type req,
   output cor_rsp_type rsp
);

   localparam int IW = $clog2(STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          mode_ff, mode_in;
   logic [IW-1:0] idx_ff, idx_in;
   cword_type     x_ff, x_in;
   cword_type     y_ff, y_in;
   cword_type     z_ff, z_in;

   cword_type     dx, dy, at;
   logic          pos;

   always_comb begin
      dx  = y_ff >>> idx_ff;
      dy  = x_ff >>> idx_ff;
      at  = atan_q30(5'(idx_ff));
      pos = mode_ff ? (y_ff <= 0) : (z_ff >= 0);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         mode_in = req.vector;
         idx_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         z_in    = req.z;
      end else if (busy_ff) begin
         if (pos) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         if (idx_ff == IW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;
   assign rsp.z    = z_ff;

endmodule

[design/sbd_sqrt.sv]
module sbd_sqrt
   import sbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_RW-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 4;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_RW-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [REM_W-1:0]  remx, trial;
   logic              ge;

   always_comb begin
      remx  = {rem_ff[ROOT_W+1:0], rad_ff[SQ_RW-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
      ge    = remx >= trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[SQ_RW-3:0], 2'b00};
         rem_in  = ge ? remx - trial : remx;
         root_in = {root_ff[ROOT_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[design/sbd_div.sv]
module sbd_div
   import sbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              done,
   output logic [DIV_NW-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_NW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_NW-1:0] q_ff, q_in;
   logic [DIV_DW:0]   rem_ff, rem_in;
   logic [DIV_DW-1:0] dvs_ff, dvs_in;

   logic [DIV_DW:0]   remx;
   logic              ge;

   always_comb begin
      remx = {rem_ff[DIV_DW-1:0], q_ff[DIV_NW-1]};
      ge   = remx >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NW - 1);
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? remx - {1'b0, dvs_ff} : remx;
         q_in   = {q_ff[DIV_NW-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[design/smart_beacon_decider.sv]
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/req_tready  fix word: position, speed, course, time
// rsp_      out        rsp_tvalid/rsp_tready  decision word: distance, interval, elapsed
// csr_      in         csr_wen                register index and data
//
// A valid fix is worked through by the sequencer; the shared CORDIC, root and divider units
// iterate one step a cycle. Speed interpolation and turn division are each skipped when
// not needed. A fix with fix_valid low goes from idle straight to the decision state.
// Reset is synchronous; it clears the sequencer, output valid and beacon state and sets the registers to defaults.
// req_tready is high only while idle; a finished word waits in the output register.
module smart_beacon_decider
   import sbd_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // latitude[27:0], longitude[56:28], speed[71:57], course[87:72], now_ms[119:88]
   input  logic [REQ_DW-1:0] req_tdata,
   // fix_valid[0]
   input  logic [0:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // distance_m[24:0], interval_ms[46:25], elapsed_ms[78:47], zero[79]
   output logic [RSP_DW-1:0] rsp_tdata,
   // send_beacon[0]
   output logic [0:0]        rsp_tuser,
   input  logic              csr_wen,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   typedef enum logic [22:0] {
      S_IDLE = 23'h000001,
      S_PREP = 23'h000002,
      S_RAD  = 23'h000004,
      S_CONV = 23'h000008,
      S_ROT  = 23'h000010,
      S_SQ1  = 23'h000020,
      S_SQ2  = 23'h000040,
      S_CC   = 23'h000080,
      S_CSQ  = 23'h000100,
      S_CSM  = 23'h000200,
      S_HAV  = 23'h000400,
      S_SQY  = 23'h000800,
      S_SQX  = 23'h001000,
      S_VEC  = 23'h002000,
      S_DM   = 23'h004000,
      S_DMW  = 23'h008000,
      S_IV   = 23'h010000,
      S_IVD  = 23'h020000,
      S_IVW  = 23'h040000,
      S_TURN = 23'h080000,
      S_TD   = 23'h100000,
      S_TW   = 23'h200000,
      S_DEC  = 23'h400000
   } st_type;

   st_type state_ff, state_in;

   logic [14:0] slow_speed_ff, slow_speed_in;
   logic [14:0] fast_speed_ff, fast_speed_in;
   logic [11:0] slow_interval_ff, slow_interval_in;
   logic [11:0] fast_interval_ff, fast_interval_in;
   logic [16:0] min_distance_ff, min_distance_in;
   logic [11:0] min_gap_ff, min_gap_in;
   logic [14:0] turn_threshold_ff, turn_threshold_in;
   logic [9:0]  turn_slope_ff, turn_slope_in;

   logic signed [27:0] last_lat_ff, last_lat_in;
   logic signed [28:0] last_lon_ff, last_lon_in;
   logic [15:0]        last_course_ff, last_course_in;
   logic [31:0]        last_beacon_ff, last_beacon_in;

   logic               fix_ff, fix_in;
   logic signed [27:0] lat_ff, lat_in;
   logic signed [28:0] lon_ff, lon_in;
   logic [14:0]        spd_ff, spd_in;
   logic [15:0]        crs_ff, crs_in;
   logic [31:0]        now_ms_ff, now_ms_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [14:0]        cdiff_ff, cdiff_in;
   logic [1:0]         k_ff, k_in;
   logic               rneg_ff, rneg_in;
   logic               flip_ff, flip_in;
   logic signed [31:0] s1_ff, s1_in;
   logic signed [31:0] s2_ff, s2_in;
   logic signed [31:0] c1_ff, c1_in;
   logic signed [31:0] c2_ff, c2_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [32:0]        sq1_ff, sq1_in;
   logic signed [31:0] sq2_ff, sq2_in;
   logic signed [31:0] cc_ff, cc_in;
   logic [32:0]        a_ff, a_in;
   logic [ROOT_W-1:0]  yr_ff, yr_in;
   logic [30:0]        z_ff, z_in;
   logic [24:0]        dist_ff, dist_in;
   logic               nq_ff, nq_in;
   logic [21:0]        rate_ff, rate_in;
   logic [21:0]        adj_ff, adj_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   logic signed [31:0] mul_a, mul_b;
   cor_req_type        cor_req;
   cor_rsp_type        cor_rsp;
   logic               sq_start, sq_done;
   logic [SQ_RW-1:0]   sq_rad;
   logic [ROOT_W-1:0]  sq_root;
   logic               div_start, div_done;
   logic [DIV_NW-1:0]  div_num, div_q;
   logic [DIV_DW-1:0]  div_den;

   logic               load, send_beacon;
   logic signed [28:0] dlat;
   logic signed [29:0] dlon, src, src_mag;
   logic [57:0]        rnd;
   logic signed [34:0] ang0, ang1, ang2;
   cword_type          sv, cv;
   logic [15:0]        ca, cb, cd;
   logic signed [35:0] tsh;
   logic signed [36:0] asum;
   logic [32:0]        a_cl;
   logic [63:0]        dround;
   logic [21:0]        slow_ms, fast_ms, gap_ms;
   logic signed [22:0] ms_diff;
   logic [16:0]        slope_v;
   logic signed [63:0] pmag;

   sbd_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .req  (cor_req),
      .rsp  (cor_rsp)
   );

   sbd_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .radicand(sq_rad),
      .done    (sq_done),
      .root    (sq_root)
   );

   sbd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      slow_speed_in     = slow_speed_ff;
      fast_speed_in     = fast_speed_ff;
      slow_interval_in  = slow_interval_ff;
      fast_interval_in  = fast_interval_ff;
      min_distance_in   = min_distance_ff;
      min_gap_in        = min_gap_ff;
      turn_threshold_in = turn_threshold_ff;
      turn_slope_in     = turn_slope_ff;
      if (csr_wen) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_SLOW_SPEED:     slow_speed_in     = csr_wdata[14:0];
            CSR_FAST_SPEED:     fast_speed_in     = csr_wdata[14:0];
            CSR_SLOW_INTERVAL:  slow_interval_in  = csr_wdata[11:0];
            CSR_FAST_INTERVAL:  fast_interval_in  = csr_wdata[11:0];
            CSR_MIN_DISTANCE:   min_distance_in   = csr_wdata[16:0];
            CSR_MIN_GAP:        min_gap_in        = csr_wdata[11:0];
            CSR_TURN_THRESHOLD: turn_threshold_in = csr_wdata[14:0];
            CSR_TURN_SLOPE:     turn_slope_in     = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      slow_ms = sec_to_ms(slow_interval_ff);
      fast_ms = sec_to_ms(fast_interval_ff);
      gap_ms  = sec_to_ms(min_gap_ff);
      ms_diff = $signed({1'b0, slow_ms}) - $signed({1'b0, fast_ms});
      slope_v = (turn_slope_ff == '0) ? 17'd100 : times_100(turn_slope_ff);

      dlat = $signed({lat_ff[27], lat_ff}) - $signed({last_lat_ff[27], last_lat_ff});
      dlon = $signed({lon_ff[28], lon_ff}) - $signed({last_lon_ff[28], last_lon_ff});
      case (k_ff)
         2'd0:    src = {dlat[28], dlat};
         2'd1:    src = dlon;
         2'd2:    src = {{2{last_lat_ff[27]}}, last_lat_ff};
         default: src = {{2{lat_ff[27]}}, lat_ff};
      endcase
      src_mag = src[29] ? -src : src;

      rnd  = prod_ff[57:0] + (k_ff[1] ? 58'h0800000 : 58'h1000000);
      ang0 = k_ff[1] ? $signed({1'b0, rnd[57:24]}) : $signed({2'b00, rnd[57:25]});
      if (rneg_ff) begin
         ang0 = -ang0;
      end
      if (ang0 > Q30_PI) begin
         ang1 = ang0 - Q30_TWO_PI;
      end else if (ang0 < -Q30_PI) begin
         ang1 = ang0 + Q30_TWO_PI;
      end else begin
         ang1 = ang0;
      end
      if (ang1 > Q30_HALF_PI) begin
         ang2 = ang1 - Q30_PI;
      end else if (ang1 < -Q30_HALF_PI) begin
         ang2 = ang1 + Q30_PI;
      end else begin
         ang2 = ang1;
      end

      sv = flip_ff ? -cor_rsp.y : cor_rsp.y;
      cv = flip_ff ? -cor_rsp.x : cor_rsp.x;

      ca = (last_course_ff >= 16'd36000) ? last_course_ff - 16'd36000 : last_course_ff;
      cb = (crs_ff >= 16'd36000) ? crs_ff - 16'd36000 : crs_ff;
      cd = (ca > cb) ? ca - cb : cb - ca;
      if (cd > 16'd18000) begin
         cd = 16'd36000 - cd;
      end

      tsh  = prod_ff[63:28];
      asum = $signed({4'b0000, sq1_ff}) + $signed({tsh[35], tsh});
      if (asum[36]) begin
         a_cl = '0;
      end else if (asum > $signed({4'b0000, ONE_Q32})) begin
         a_cl = ONE_Q32;
      end else begin
         a_cl = asum[32:0];
      end

      dround = prod_ff + 64'h20000000;
      pmag   = prod_ff[63] ? -prod_ff : prod_ff;

      send_beacon = fix_ff && (elapsed_ff >= {10'b0, gap_ms}) &&
                    ((dist_ff >= {8'b0, min_distance_ff}) || (elapsed_ff >= {10'b0, adj_ff}));
   end

   always_comb begin
      state_in       = state_ff;
      last_lat_in    = last_lat_ff;
      last_lon_in    = last_lon_ff;
      last_course_in = last_course_ff;
      last_beacon_in = last_beacon_ff;
      fix_in         = fix_ff;
      lat_in         = lat_ff;
      lon_in         = lon_ff;
      spd_in         = spd_ff;
      crs_in         = crs_ff;
      now_ms_in      = now_ms_ff;
      elapsed_in     = elapsed_ff;
      cdiff_in       = cdiff_ff;
      k_in           = k_ff;
      rneg_in        = rneg_ff;
      flip_in        = flip_ff;
      s1_in          = s1_ff;
      s2_in          = s2_ff;
      c1_in          = c1_ff;
      c2_in          = c2_ff;
      sq1_in         = sq1_ff;
      sq2_in         = sq2_ff;
      cc_in          = cc_ff;
      a_in           = a_ff;
      yr_in          = yr_ff;
      z_in           = z_ff;
      dist_in        = dist_ff;
      nq_in          = nq_ff;
      rate_in        = rate_ff;
      adj_in         = adj_ff;
      mul_a          = '0;
      mul_b          = '0;
      cor_req        = '0;
      sq_start       = 1'b0;
      sq_rad         = '0;
      div_start      = 1'b0;
      div_num        = '0;
      div_den        = '0;
      load           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               fix_in    = req_tuser[0];
               lat_in    = $signed(req_tdata[27:0]);
               lon_in    = $signed(req_tdata[56:28]);
               spd_in    = req_tdata[71:57];
               crs_in    = req_tdata[87:72];
               now_ms_in = req_tdata[119:88];
               state_in  = req_tuser[0] ? S_PREP : S_DEC;
            end
         end
         S_PREP: begin
            elapsed_in = now_ms_ff - last_beacon_ff;
            cdiff_in   = cd[14:0];
            k_in       = '0;
            state_in   = S_RAD;
         end
         S_RAD: begin
            mul_a    = {3'b000, src_mag[28:0]};
            mul_b    = UDEG_TO_RAD;
            rneg_in  = src[29];
            state_in = S_CONV;
         end
         S_CONV: begin
            cor_req.start  = 1'b1;
            cor_req.vector = 1'b0;
            cor_req.x      = CORDIC_K;
            cor_req.y      = '0;
            cor_req.z      = ang2[CW-1:0];
            flip_in        = (ang1 > Q30_HALF_PI) || (ang1 < -Q30_HALF_PI);
            state_in       = S_ROT;
         end
         S_ROT: begin
            if (cor_rsp.done) begin
               case (k_ff)
                  2'd0:    s1_in = sv[31:0];
                  2'd1:    s2_in = sv[31:0];
                  2'd2:    c1_in = cv[31:0];
                  default: c2_in = cv[31:0];
               endcase
               if (k_ff == 2'd3) begin
                  state_in = S_SQ1;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_RAD;
               end
            end
         end
         S_SQ1: begin
            mul_a    = s1_ff;
            mul_b    = s1_ff;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            sq1_in   = prod_ff[60:28];
            mul_a    = s2_ff;
            mul_b    = s2_ff;
            state_in = S_CC;
         end
         S_CC: begin
            sq2_in   = prod_ff[61:30];
            mul_a    = c1_ff;
            mul_b    = c2_ff;
            state_in = S_CSQ;
         end
         S_CSQ: begin
            cc_in    = prod_ff[61:30];
            state_in = S_CSM;
         end
         S_CSM: begin
            mul_a    = cc_ff;
            mul_b    = sq2_ff;
            state_in = S_HAV;
         end
         S_HAV: begin
            a_in     = a_cl;
            sq_start = 1'b1;
            sq_rad   = {1'b0, a_cl, 28'b0};
            state_in = S_SQY;
         end
         S_SQY: begin
            if (sq_done) begin
               yr_in    = sq_root;
               sq_start = 1'b1;
               sq_rad   = {1'b0, ONE_Q32 - a_ff, 28'b0};
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            if (sq_done) begin
               cor_req.start  = 1'b1;
               cor_req.vector = 1'b1;
               cor_req.x      = {3'b000, sq_root};
               cor_req.y      = {3'b000, yr_ff};
               cor_req.z      = '0;
               state_in       = S_VEC;
            end
         end
         S_VEC: begin
            if (cor_rsp.done) begin
               if (cor_rsp.z[CW-1]) begin
                  z_in = '0;
               end else if (cor_rsp.z > cword_type'(Q30_HALF_PI)) begin
                  z_in = Q30_HALF_PI[30:0];
               end else begin
                  z_in = cor_rsp.z[30:0];
               end
               state_in = S_DM;
            end
         end
         S_DM: begin
            mul_a    = {1'b0, z_ff};
            mul_b    = EARTH_2R;
            state_in = S_DMW;
         end
         S_DMW: begin
            dist_in  = dround[54:30];
            state_in = S_IV;
         end
         S_IV: begin
            if (spd_ff < slow_speed_ff) begin
               rate_in  = slow_ms;
               state_in = S_TURN;
            end else if (spd_ff > fast_speed_ff) begin
               rate_in  = fast_ms;
               state_in = S_TURN;
            end else if (fast_speed_ff == slow_speed_ff) begin
               rate_in  = slow_ms;
               state_in = S_TURN;
            end else begin
               mul_a    = {17'b0, spd_ff - slow_speed_ff};
               mul_b    = {{9{ms_diff[22]}}, ms_diff};
               state_in = S_IVD;
            end
         end
         S_IVD: begin
            nq_in     = prod_ff[63];
            div_start = 1'b1;
            div_num   = pmag[DIV_NW-1:0];
            div_den   = {2'b00, fast_speed_ff - slow_speed_ff};
            state_in  = S_IVW;
         end
         S_IVW: begin
            if (div_done) begin
               rate_in  = nq_ff ? slow_ms + div_q[21:0] : slow_ms - div_q[21:0];
               state_in = S_TURN;
            end
         end
         S_TURN: begin
            if (cdiff_ff >= turn_threshold_ff) begin
               mul_a    = {10'b0, rate_ff};
               mul_b    = {15'b0, slope_v};
               state_in = S_TD;
            end else begin
               adj_in   = rate_ff;
               state_in = S_DEC;
            end
         end
         S_TD: begin
            div_start = 1'b1;
            div_num   = prod_ff[DIV_NW-1:0];
            div_den   = slope_v + {2'b00, cdiff_ff};
            state_in  = S_TW;
         end
         S_TW: begin
            if (div_done) begin
               adj_in   = div_q[21:0];
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = S_IDLE;
               if (send_beacon) begin
                  last_lat_in    = lat_ff;
                  last_lon_in    = lon_ff;
                  last_course_in = crs_ff;
                  last_beacon_in = now_ms_ff;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      prod_in      = mul_a * mul_b;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fix_ff ? {1'b0, elapsed_ff, adj_ff, dist_ff} : '0;
         rsp_user_in  = send_beacon;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         slow_speed_ff     <= 15'd100;
         fast_speed_ff     <= 15'd600;
         slow_interval_ff  <= 12'd300;
         fast_interval_ff  <= 12'd60;
         min_distance_ff   <= 17'd100;
         min_gap_ff        <= 12'd40;
         turn_threshold_ff <= 15'd2800;
         turn_slope_ff     <= 10'd255;
         last_lat_ff       <= '0;
         last_lon_ff       <= '0;
         last_course_ff    <= '0;
         last_beacon_ff    <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         slow_speed_ff     <= slow_speed_in;
         fast_speed_ff     <= fast_speed_in;
         slow_interval_ff  <= slow_interval_in;
         fast_interval_ff  <= fast_interval_in;
         min_distance_ff   <= min_distance_in;
         min_gap_ff        <= min_gap_in;
         turn_threshold_ff <= turn_threshold_in;
         turn_slope_ff     <= turn_slope_in;
         last_lat_ff       <= last_lat_in;
         last_lon_ff       <= last_lon_in;
         last_course_ff    <= last_course_in;
         last_beacon_ff    <= last_beacon_in;
      end
   end

   always_ff @(posedge clock) begin
      fix_ff      <= fix_in;
      lat_ff      <= lat_in;
      lon_ff      <= lon_in;
      spd_ff      <= spd_in;
      crs_ff      <= crs_in;
      now_ms_ff   <= now_ms_in;
      elapsed_ff  <= elapsed_in;
      cdiff_ff    <= cdiff_in;
      k_ff        <= k_in;
      rneg_ff     <= rneg_in;
      flip_ff     <= flip_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      prod_ff     <= prod_in;
      sq1_ff      <= sq1_in;
      sq2_ff      <= sq2_in;
      cc_ff       <= cc_in;
      a_ff        <= a_in;
      yr_ff       <= yr_in;
      z_ff        <= z_in;
      dist_ff     <= dist_in;
      nq_ff       <= nq_in;
      rate_ff     <= rate_in;
      adj_ff      <= adj_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   a_beacon_updates_time: assert property (@(posedge clock) disable iff (reset)
      (load && send_beacon) |=> (last_beacon_ff == $past(now_ms_ff)))
      else $error("beacon time not stored");

   a_no_fix_zero_word: assert property (@(posedge clock) disable iff (reset)
      (load && !fix_ff) |=> (rsp_data_ff == '0 && !rsp_user_ff))
      else $error("word for missing fix not zero");

   a_cordic_start_idle: assert property (@(posedge clock) disable iff (reset)
      cor_req.start |-> !cor_rsp.busy)
      else $error("cordic started while busy");

   a_adj_not_above_rate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC && fix_ff) |-> (adj_ff <= rate_ff))
      else $error("turn adjustment lengthened interval");

endmodule
